[rtl/vpsm_pkg.sv]
// Package: shared widths, register indexes, reset values and the geometry struct.
`default_nettype none
package vpsm_pkg;

  localparam int COORD_BITS    = 12;
  localparam int DIM_BITS      = 13;
  localparam int CHAIN_BITS    = 7;
  localparam int PAR_BITS      = 4;
  localparam int QUO_BITS      = 20;  // widest setup dividend: phys_height * chain_len
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 13;
  localparam int DIV_STEPS     = 2;   // quotient bits resolved per pipeline stage
  localparam int DIV_STAGES    = (COORD_BITS + DIV_STEPS - 1) / DIV_STEPS;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PHYS_WIDTH     = cfg_idx_t'(0);
  localparam cfg_idx_t REG_PHYS_HEIGHT    = cfg_idx_t'(1);
  localparam cfg_idx_t REG_CHAIN_LEN      = cfg_idx_t'(2);
  localparam cfg_idx_t REG_PARALLEL_COUNT = cfg_idx_t'(3);
  localparam cfg_idx_t REG_FLIP_ALTERNATE = cfg_idx_t'(4);

  localparam logic [DIM_BITS-1:0]   RST_PHYS_WIDTH     = DIM_BITS'(64);
  localparam logic [DIM_BITS-1:0]   RST_PHYS_HEIGHT    = DIM_BITS'(32);
  localparam logic [CHAIN_BITS-1:0] RST_CHAIN_LEN      = CHAIN_BITS'(1);
  localparam logic [PAR_BITS-1:0]   RST_PARALLEL_COUNT = PAR_BITS'(1);

  // Derived geometry; held steady for items in flight by the user, not the block.
  typedef struct packed {
    logic [DIM_BITS-1:0] pw;
    logic [DIM_BITS-1:0] ph;
    logic [QUO_BITS-1:0] vis_w;
    logic [QUO_BITS-1:0] vis_h;
    logic                wpp_odd;  // parity of panels per physical row
    logic                flip;
    logic                invalid;
  } geom_t;

endpackage
`default_nettype wire

[rtl/vpsm_in_if.sv]
// Input channel interface: visible coordinate item.
`default_nettype none
interface vpsm_in_if;
  import vpsm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] vis_x;
  logic [COORD_BITS-1:0] vis_y;

  modport source (output valid, output vis_x, output vis_y, input ready);
  modport sink   (input valid, input vis_x, input vis_y, output ready);
endinterface
`default_nettype wire

[rtl/vpsm_out_if.sv]
// Result channel interface: physical coordinate item.
`default_nettype none
interface vpsm_out_if;
  import vpsm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] mat_x;
  logic [COORD_BITS-1:0] mat_y;
  logic                  outside;

  modport source (output valid, output mat_x, output mat_y, output outside, input ready);
  modport sink   (input valid, input mat_x, input mat_y, input outside, output ready);
endinterface
`default_nettype wire

[rtl/vpsm_setup.sv]
// Config registers and iterative divider that derives the panel geometry.
`default_nettype none
module vpsm_setup (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [vpsm_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [vpsm_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output vpsm_pkg::geom_t                    geom,
  output logic                               geom_ok
);
  import vpsm_pkg::*;

  localparam int CNT_BITS = $clog2(QUO_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(QUO_BITS - 1);

  typedef enum logic [1:0] {S_LOAD, S_ITER, S_DONE} state_t;
  typedef enum logic [2:0] {OP_PW, OP_PH, OP_VW, OP_VH, OP_WPP} op_t;

  state_t                  state_r;
  op_t                     op_r;
  op_t                     op_nxt;
  logic [DIM_BITS-1:0]     phys_width_r;
  logic [DIM_BITS-1:0]     phys_height_r;
  logic [CHAIN_BITS-1:0]   chain_len_r;
  logic [PAR_BITS-1:0]     parallel_count_r;
  logic                    flip_alternate_r;

  logic [DIM_BITS-1:0]     rem_r;
  logic [QUO_BITS-1:0]     nq_r;
  logic [DIM_BITS-1:0]     dvs_r;
  logic [CNT_BITS-1:0]     cnt_r;

  logic [DIM_BITS-1:0]     pw_r;
  logic [DIM_BITS-1:0]     ph_r;
  logic [QUO_BITS-1:0]     vis_w_r;
  logic [QUO_BITS-1:0]     vis_h_r;
  logic                    wpp_odd_r;

  logic [QUO_BITS-1:0]     dividend;
  logic [DIM_BITS-1:0]     divisor;
  logic [DIM_BITS:0]       trial;
  logic                    ge;
  logic [DIM_BITS-1:0]     rem_nxt;
  logic [QUO_BITS-1:0]     nq_nxt;

  always_comb begin
    unique case (op_r)
      OP_PW: begin
        dividend = QUO_BITS'(phys_width_r);
        divisor  = DIM_BITS'(chain_len_r);
      end
      OP_PH: begin
        dividend = QUO_BITS'(phys_height_r);
        divisor  = DIM_BITS'(parallel_count_r);
      end
      OP_VW: begin
        dividend = QUO_BITS'(phys_width_r * QUO_BITS'(parallel_count_r));
        divisor  = DIM_BITS'(chain_len_r);
      end
      OP_VH: begin
        dividend = QUO_BITS'(phys_height_r) * QUO_BITS'(chain_len_r);
        divisor  = DIM_BITS'(parallel_count_r);
      end
      OP_WPP: begin
        dividend = QUO_BITS'(phys_width_r);
        divisor  = pw_r;
      end
      default: begin
        dividend = '0;
        divisor  = '0;
      end
    endcase
  end

  always_comb begin
    unique case (op_r)
      OP_PW:   op_nxt = OP_PH;
      OP_PH:   op_nxt = OP_VW;
      OP_VW:   op_nxt = OP_VH;
      OP_VH:   op_nxt = OP_WPP;
      default: op_nxt = OP_WPP;
    endcase
  end

  // One restoring step per cycle.
  always_comb begin
    trial   = {rem_r, nq_r[QUO_BITS-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? DIM_BITS'(trial - {1'b0, dvs_r}) : trial[DIM_BITS-1:0];
    nq_nxt  = {nq_r[QUO_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_LOAD;
      op_r             <= OP_PW;
      phys_width_r     <= RST_PHYS_WIDTH;
      phys_height_r    <= RST_PHYS_HEIGHT;
      chain_len_r      <= RST_CHAIN_LEN;
      parallel_count_r <= RST_PARALLEL_COUNT;
      flip_alternate_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PHYS_WIDTH:     phys_width_r     <= cfg_data[DIM_BITS-1:0];
        REG_PHYS_HEIGHT:    phys_height_r    <= cfg_data[DIM_BITS-1:0];
        REG_CHAIN_LEN:      chain_len_r      <= cfg_data[CHAIN_BITS-1:0];
        REG_PARALLEL_COUNT: parallel_count_r <= cfg_data[PAR_BITS-1:0];
        REG_FLIP_ALTERNATE: flip_alternate_r <= cfg_data[0];
        default: ;
      endcase
      state_r <= S_LOAD;
      op_r    <= OP_PW;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          rem_r   <= '0;
          nq_r    <= dividend;
          dvs_r   <= divisor;
          cnt_r   <= '0;
          state_r <= S_ITER;
        end
        S_ITER: begin
          rem_r <= rem_nxt;
          nq_r  <= nq_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            unique case (op_r)
              OP_PW:   pw_r      <= nq_nxt[DIM_BITS-1:0];
              OP_PH:   ph_r      <= nq_nxt[DIM_BITS-1:0];
              OP_VW:   vis_w_r   <= nq_nxt;
              OP_VH:   vis_h_r   <= nq_nxt;
              OP_WPP:  wpp_odd_r <= nq_nxt[0];
              default: ;
            endcase
            if (op_r == OP_WPP) begin
              state_r <= S_DONE;
            end else begin
              op_r    <= op_nxt;
              state_r <= S_LOAD;
            end
          end
        end
        S_DONE: ;
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign geom_ok       = (state_r == S_DONE);
  assign geom.pw       = pw_r;
  assign geom.ph       = ph_r;
  assign geom.vis_w    = vis_w_r;
  assign geom.vis_h    = vis_h_r;
  assign geom.wpp_odd  = wpp_odd_r;
  assign geom.flip     = flip_alternate_r;
  assign geom.invalid  = (chain_len_r == '0) || (parallel_count_r == '0) ||
                         (pw_r == '0) || (ph_r == '0);

endmodule
`default_nettype wire

[rtl/vpsm_pipe.sv]
// Per-item pipeline: range check, pipelined divides, panel multiply, final add.
`default_nettype none
module vpsm_pipe (
  input  logic            clk,
  input  logic            rst_n,
  input  vpsm_pkg::geom_t geom,
  input  logic            accept_en,
  vpsm_in_if.sink         in_ch,
  vpsm_out_if.source      out_ch
);
  import vpsm_pkg::*;

  typedef struct packed {
    logic [DIM_BITS-1:0]   rem;
    logic [COORD_BITS-1:0] nq;   // dividend bits shift out, quotient bits shift in
  } cdiv_t;

  typedef struct packed {
    logic  outside;
    cdiv_t dx;
    cdiv_t dy;
  } stg_t;

  typedef struct packed {
    logic                  outside;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [COORD_BITS-1:0] xin;
    logic [COORD_BITS-1:0] yin;
  } mul_t;

  typedef struct packed {
    logic                  outside;
    logic [COORD_BITS-1:0] mat_x;
    logic [COORD_BITS-1:0] mat_y;
  } res_t;

  function automatic cdiv_t cdiv_step(cdiv_t s, logic [DIM_BITS-1:0] d);
    logic [DIM_BITS:0] t;
    logic              ge;
    cdiv_t             r;
    t     = {s.rem, s.nq[COORD_BITS-1]};
    ge    = t >= {1'b0, d};
    r.rem = ge ? DIM_BITS'(t - {1'b0, d}) : t[DIM_BITS-1:0];
    r.nq  = {s.nq[COORD_BITS-2:0], ge};
    return r;
  endfunction

  stg_t                stg_r   [DIV_STAGES+1];
  stg_t                stg_nxt [DIV_STAGES+1];
  logic [DIV_STAGES:0] v_r;
  logic [DIV_STAGES:0] adv;
  mul_t                mul_r;
  mul_t                mul_nxt;
  logic                mul_v_r;
  logic                mul_adv;
  res_t                out_r;
  res_t                out_nxt;
  logic                out_v_r;
  logic                out_adv;
  logic                in_fire;

  logic [COORD_BITS-1:0] prow;
  logic [COORD_BITS-1:0] pw_c;
  logic [COORD_BITS-1:0] ph_c;
  logic [COORD_BITS-1:0] xin;
  logic [COORD_BITS-1:0] yin;
  logic                  flip;

  // Backpressure: a stage moves when it is empty or the next one moves.
  always_comb begin
    out_adv         = !out_v_r || out_ch.ready;
    mul_adv         = !mul_v_r || out_adv;
    adv[DIV_STAGES] = !v_r[DIV_STAGES] || mul_adv;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ch.ready = accept_en && adv[0];
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    stg_t tmp;
    stg_nxt[0].outside = geom.invalid ||
                         (QUO_BITS'(in_ch.vis_x) >= geom.vis_w) ||
                         (QUO_BITS'(in_ch.vis_y) >= geom.vis_h);
    stg_nxt[0].dx.rem  = '0;
    stg_nxt[0].dx.nq   = in_ch.vis_x;
    stg_nxt[0].dy.rem  = '0;
    stg_nxt[0].dy.nq   = in_ch.vis_y;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      tmp = stg_r[k-1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        if ((k - 1) * DIV_STEPS + j < COORD_BITS) begin
          tmp.dx = cdiv_step(tmp.dx, geom.pw);
          tmp.dy = cdiv_step(tmp.dy, geom.ph);
        end
      end
      stg_nxt[k] = tmp;
    end
  end

  // Panel origin and in-panel offset, with the 180 degree turn applied.
  always_comb begin
    prow            = stg_r[DIV_STAGES].dy.nq;
    pw_c            = COORD_BITS'(geom.pw);
    ph_c            = COORD_BITS'(geom.ph);
    xin             = COORD_BITS'(stg_r[DIV_STAGES].dx.rem);
    yin             = COORD_BITS'(stg_r[DIV_STAGES].dy.rem);
    flip            = geom.flip && (geom.wpp_odd == prow[0]);
    mul_nxt.outside = stg_r[DIV_STAGES].outside;
    mul_nxt.px      = prow * pw_c;
    mul_nxt.py      = stg_r[DIV_STAGES].dx.nq * ph_c;
    mul_nxt.xin     = flip ? pw_c - xin - COORD_BITS'(1) : xin;
    mul_nxt.yin     = flip ? ph_c - yin - COORD_BITS'(1) : yin;
  end

  always_comb begin
    out_nxt.outside = mul_r.outside;
    out_nxt.mat_x   = mul_r.outside ? '0 : mul_r.px + mul_r.xin;
    out_nxt.mat_y   = mul_r.outside ? '0 : mul_r.py + mul_r.yin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      mul_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_fire;
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (mul_adv) begin
        mul_v_r <= v_r[DIV_STAGES];
      end
      if (out_adv) begin
        out_v_r <= mul_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= DIV_STAGES; k++) begin
      if (adv[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
    if (mul_adv) begin
      mul_r <= mul_nxt;
    end
    if (out_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.mat_x   = out_r.mat_x;
  assign out_ch.mat_y   = out_r.mat_y;
  assign out_ch.outside = out_r.outside;

endmodule
`default_nettype wire

[rtl/vertical_panel_stack_mapper.sv]
// Top level: vertical panel stack coordinate mapper.
//
//   Channel  Dir  Handshake        Fields
//   in_ch    in   valid / ready    vis_x[11:0], vis_y[11:0]
//   out_ch   out  valid / ready    mat_x[11:0], mat_y[11:0], outside
//   cfg_*    in   cfg_we           cfg_idx[2:0], cfg_data[12:0]
//
// One item per clock sustained while geometry is ready and out_ch is not stalled; each item
// passes the range check, the two-bits-per-stage divide pipeline, multiply and add.
// After reset and after every config write a geometry pass runs in the shared
// iterative divider: five divides in turn, with in_ch.ready low throughout.
// Reset is synchronous, active low. A stalled output holds; every stage
// advances only into an empty or moving successor, so nothing is dropped.
`default_nettype none
module vertical_panel_stack_mapper (
  input  logic                               clk,
  input  logic                               rst_n,
  vpsm_in_if.sink                            in_ch,
  vpsm_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [vpsm_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [vpsm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import vpsm_pkg::*;

  geom_t geom;
  logic  geom_ok;
  logic  accept_en;

  vpsm_setup u_setup (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .geom     (geom),
    .geom_ok  (geom_ok)
  );

  // No item enters while geometry is being rebuilt or rewritten.
  assign accept_en = geom_ok && !cfg_we;

  vpsm_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .accept_en (accept_en),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

[rtl/vpsm_chk.sv]
// Port-level checker for the mapper, bound to the top level.
`default_nettype none
module vpsm_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [vpsm_pkg::COORD_BITS-1:0]    mat_x,
  input logic [vpsm_pkg::COORD_BITS-1:0]    mat_y,
  input logic                               outside,
  input logic                               cfg_we
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(mat_x) && $stable(mat_y) &&
                                $stable(outside))
    else $error("stalled result item changed or dropped");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && outside |-> (mat_x == '0) && (mat_y == '0))
    else $error("outside item carries nonzero coordinates");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !in_ready)
    else $error("item accepted during config write");

  a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("item accepted before geometry rebuilt");

  a_no_accept_unused: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !cfg_we)
    else $error("item and config write in the same cycle");

endmodule

bind vertical_panel_stack_mapper vpsm_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .mat_x     (out_ch.mat_x),
  .mat_y     (out_ch.mat_y),
  .outside   (out_ch.outside),
  .cfg_we    (cfg_we)
);
`default_nettype wire
